@@ hw/rtl/ilhp_pkg.sv @@
// shared types and constants of the ipv4 / l4 header parser
package ilhp_pkg;

	localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
	localparam logic [15:0] IP_MIN_HDR   = 16'd20;
	localparam logic [15:0] TCP_MIN_HDR  = 16'd20;
	localparam logic [15:0] UDP_HDR      = 16'd8;
	localparam logic [7:0]  PROTO_TCP    = 8'd6;
	localparam logic [7:0]  PROTO_UDP    = 8'd17;
	localparam logic [3:0]  IP_VERSION   = 4'd4;
	localparam logic [31:0] QUIC_V1      = 32'h00000001;
	localparam logic [31:0] QUIC_V2      = 32'h6b3343cf;
	localparam logic [7:0]  TLS_HANDSHAKE = 8'h16;
	localparam logic [7:0]  TLS_CLIENT_HELLO = 8'h01;
	localparam logic [15:0] QUIC_MIN_LEN = 16'd5;
	localparam logic [15:0] TLS_MIN_LEN  = 16'd6;

	typedef enum logic [2:0] {
		KIND_BAD_IP  = 3'd0,
		KIND_OTHER   = 3'd1,
		KIND_TCP_OK  = 3'd2,
		KIND_TCP_BAD = 3'd3,
		KIND_UDP_OK  = 3'd4,
		KIND_UDP_BAD = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		CLASS_NONE      = 2'd0,
		CLASS_QUIC_INIT = 2'd1,
		CLASS_TLS_HELLO = 2'd2
	} payload_class_t;

	// per-packet header state, also the snapshot handed on at the end of a packet
	typedef struct packed {
		logic [15:0] byte_count;
		logic [7:0]  version_ihl;
		logic [15:0] ip_total_len;
		logic [7:0]  proto;
		logic [31:0] ip_src;
		logic [31:0] ip_dst;
		logic [31:0] port_pair;
		logic [63:0] seq_ack_pair;
		logic [31:0] offset_flags_window;
		logic [47:0] payload_head;
	} hdr_state_t;

	typedef struct packed {
		kind_t          kind;
		logic [7:0]     protocol;
		logic [31:0]    ip_src;
		logic [31:0]    ip_dst;
		logic [15:0]    l4_sport;
		logic [15:0]    l4_dport;
		logic [31:0]    seq_num;
		logic [31:0]    ack_num;
		logic [5:0]     tcp_flags;
		logic [15:0]    window_size;
		logic [15:0]    data_len;
		payload_class_t payload_class;
	} result_t;

endpackage

@@ hw/rtl/ilhp_if.sv @@
// byte and result channel interfaces of the header parser
interface ilhp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_packet;

	modport source (output valid, output data_byte, output end_of_packet, input ready);
	modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

interface ilhp_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [7:0]  protocol;
	logic [31:0] ip_src;
	logic [31:0] ip_dst;
	logic [15:0] l4_sport;
	logic [15:0] l4_dport;
	logic [31:0] seq_num;
	logic [31:0] ack_num;
	logic [5:0]  tcp_flags;
	logic [15:0] window_size;
	logic [15:0] data_len;
	logic [1:0]  payload_class;

	modport source (output valid, output kind, output protocol, output ip_src,
		output ip_dst, output l4_sport, output l4_dport, output seq_num,
		output ack_num, output tcp_flags, output window_size, output data_len,
		output payload_class, input ready);
	modport sink (input valid, input kind, input protocol, input ip_src,
		input ip_dst, input l4_sport, input l4_dport, input seq_num,
		input ack_num, input tcp_flags, input window_size, input data_len,
		input payload_class, output ready);
endinterface

@@ hw/rtl/ipv4_l4_header_parser.sv @@
// top level of the ipv4 / tcp / udp header parser
//
//   channel   role    request                          when
//   packet    sink    one packet byte, last one marked  valid && ready
//   result    source  one parsed header summary         valid && ready
//
// a new byte is accepted in every cycle while packet.ready is high
// a result goes from the marked byte through the snapshot stage, then the result register
// reset clears the header state and both valid flags; no clearing pass
// a stalled result holds the snapshot stage, and bytes are refused only while
// both the snapshot and the result register are occupied and the result is held
module ipv4_l4_header_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	ilhp_byte_if.sink            packet,
	ilhp_result_if.source        result
);
	import ilhp_pkg::*;

	hdr_state_t snap_s1;
	result_t    res_s2;
	logic       snap_v_s1;
	logic       res_v_s2;
	logic       accept;
	logic       advance;
	logic       load;

	// result register free or being emptied this cycle
	assign advance      = !res_v_s2 || result.ready;
	assign load         = snap_v_s1 && advance;
	assign packet.ready = !snap_v_s1 || advance;
	assign accept       = packet.valid && packet.ready;

	ilhp_capture u_capture (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (packet.data_byte),
		.end_of_packet (packet.end_of_packet),
		.snap_s1       (snap_s1)
	);

	ilhp_classify u_classify (
		.clk     (clk),
		.load    (load),
		.snap_s1 (snap_s1),
		.res_s2  (res_s2)
	);

	// snapshot stage holds one finished packet awaiting classification
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_v_s1 <= 1'b0;
		end else if (accept && packet.end_of_packet) begin
			snap_v_s1 <= 1'b1;
		end else if (load) begin
			snap_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_s2 <= 1'b0;
		end else if (load) begin
			res_v_s2 <= 1'b1;
		end else if (result.ready) begin
			res_v_s2 <= 1'b0;
		end
	end

	assign result.valid         = res_v_s2;
	assign result.kind          = res_s2.kind;
	assign result.protocol      = res_s2.protocol;
	assign result.ip_src        = res_s2.ip_src;
	assign result.ip_dst        = res_s2.ip_dst;
	assign result.l4_sport      = res_s2.l4_sport;
	assign result.l4_dport      = res_s2.l4_dport;
	assign result.seq_num       = res_s2.seq_num;
	assign result.ack_num       = res_s2.ack_num;
	assign result.tcp_flags     = res_s2.tcp_flags;
	assign result.window_size   = res_s2.window_size;
	assign result.data_len      = res_s2.data_len;
	assign result.payload_class = res_s2.payload_class;

endmodule

@@ hw/rtl/ilhp_capture.sv @@
// per-byte header field capture and end-of-packet snapshot
module ilhp_capture (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          data_byte,
	input  logic                end_of_packet,
	output ilhp_pkg::hdr_state_t snap_s1
);
	import ilhp_pkg::*;

	hdr_state_t  cur_q;
	hdr_state_t  nxt;
	logic [15:0] pos;
	logic [15:0] hl;
	logic [15:0] r;
	logic [15:0] ps;
	logic [15:0] d;
	logic        have_ps;
	logic [2:0]  k;

	always_comb begin
		nxt     = cur_q;
		pos     = cur_q.byte_count;
		hl      = {10'd0, cur_q.version_ihl[3:0], 2'b00};
		r       = pos - hl;
		ps      = '0;
		have_ps = 1'b0;
		d       = '0;
		k       = '0;
		if (pos != COUNT_MAX) begin
			nxt.byte_count = pos + 16'd1;
			if (pos == 16'd0)
				nxt.version_ihl = data_byte;
			if (pos == 16'd2 || pos == 16'd3)
				nxt.ip_total_len[{~pos[0], 3'b000} +: 8] = data_byte;
			if (pos == 16'd9)
				nxt.proto = data_byte;
			if (pos >= 16'd12 && pos < 16'd16)
				nxt.ip_src[{~pos[1:0], 3'b000} +: 8] = data_byte;
			if (pos >= 16'd16 && pos < 16'd20)
				nxt.ip_dst[{~pos[1:0], 3'b000} +: 8] = data_byte;

			// l4 bytes start at the header length taken from byte 0
			if (pos != 16'd0 && pos >= hl) begin
				if (r < 16'd4)
					nxt.port_pair[{~r[1:0], 3'b000} +: 8] = data_byte;
				else if (r < 16'd12)
					nxt.seq_ack_pair[{r[2], ~r[1:0], 3'b000} +: 8] = data_byte;
				else if (r < 16'd16)
					nxt.offset_flags_window[{~r[1:0], 3'b000} +: 8] = data_byte;

				if (nxt.proto == PROTO_UDP) begin
					ps      = UDP_HDR;
					have_ps = 1'b1;
				end else if (nxt.proto == PROTO_TCP) begin
					ps      = {10'd0, nxt.offset_flags_window[31:28], 2'b00};
					have_ps = (ps >= TCP_MIN_HDR);
				end
				d = r - ps;
				k = d[2:0];
				if (have_ps && r >= ps && d < 16'd6)
					nxt.payload_head[{3'd5 - k, 3'b000} +: 8] = data_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (accept) begin
			if (end_of_packet)
				cur_q <= '0;
			else
				cur_q <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && end_of_packet)
			snap_s1 <= nxt;
	end

endmodule

@@ hw/rtl/ilhp_classify.sv @@
// header checks, l4 decode and payload classification into the result register
module ilhp_classify (
	input  logic                 clk,
	input  logic                 load,
	input  ilhp_pkg::hdr_state_t snap_s1,
	output ilhp_pkg::result_t    res_s2
);
	import ilhp_pkg::*;

	result_t     res;
	logic [15:0] len;
	logic [15:0] hl;
	logic [15:0] total;
	logic [16:0] l4;
	logic [15:0] doff;
	logic [15:0] plen;
	logic [31:0] quic_ver;
	logic        bad_ip;
	logic        l4_neg;

	always_comb begin
		res      = '0;
		len      = snap_s1.byte_count;
		hl       = {10'd0, snap_s1.version_ihl[3:0], 2'b00};
		total    = (snap_s1.ip_total_len > len) ? len : snap_s1.ip_total_len;
		l4       = {1'b0, total} - {1'b0, hl};
		l4_neg   = l4[16];
		doff     = {10'd0, snap_s1.offset_flags_window[31:28], 2'b00};
		quic_ver = snap_s1.payload_head[39:8];
		plen     = '0;
		bad_ip   = len < IP_MIN_HDR || snap_s1.version_ihl[7:4] != IP_VERSION ||
			hl < IP_MIN_HDR || hl > len;

		if (bad_ip) begin
			res.kind = KIND_BAD_IP;
		end else begin
			res.protocol = snap_s1.proto;
			res.ip_src   = snap_s1.ip_src;
			res.ip_dst   = snap_s1.ip_dst;
			if (snap_s1.proto == PROTO_UDP) begin
				if (l4_neg || l4[15:0] < UDP_HDR) begin
					res.kind = KIND_UDP_BAD;
				end else begin
					plen          = l4[15:0] - UDP_HDR;
					res.kind      = KIND_UDP_OK;
					res.l4_sport  = snap_s1.port_pair[31:16];
					res.l4_dport  = snap_s1.port_pair[15:0];
					res.data_len  = plen;
					// long header form with a known quic version
					if (plen >= QUIC_MIN_LEN && snap_s1.payload_head[47] &&
						(quic_ver == QUIC_V1 || quic_ver == QUIC_V2))
						res.payload_class = CLASS_QUIC_INIT;
				end
			end else if (snap_s1.proto == PROTO_TCP) begin
				if (l4_neg || l4[15:0] < TCP_MIN_HDR || doff < TCP_MIN_HDR ||
					doff > l4[15:0]) begin
					res.kind = KIND_TCP_BAD;
				end else begin
					plen            = l4[15:0] - doff;
					res.kind        = KIND_TCP_OK;
					res.l4_sport    = snap_s1.port_pair[31:16];
					res.l4_dport    = snap_s1.port_pair[15:0];
					res.seq_num     = snap_s1.seq_ack_pair[63:32];
					res.ack_num     = snap_s1.seq_ack_pair[31:0];
					res.tcp_flags   = snap_s1.offset_flags_window[21:16];
					res.window_size = snap_s1.offset_flags_window[15:0];
					res.data_len    = plen;
					if (plen >= TLS_MIN_LEN &&
						snap_s1.payload_head[47:40] == TLS_HANDSHAKE &&
						snap_s1.payload_head[7:0] == TLS_CLIENT_HELLO)
						res.payload_class = CLASS_TLS_HELLO;
				end
			end else begin
				res.kind = KIND_OTHER;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_s2 <= res;
	end

endmodule

@@ test/header_parse_scoreboard.sv @@
// scoreboard for the header parser: predicts each packet summary and compares it
module header_parse_scoreboard (
	input  logic   clk,
	input  logic   arst_n,
	ilhp_byte_if   packet,
	ilhp_result_if result,
	output int     mismatches,
	output int     pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import ilhp_pkg::*;

	// per-packet header capture
	logic [15:0] rx_count;
	logic [7:0]  ver_ihl;
	logic [15:0] tot_len;
	logic [7:0]  proto;
	logic [31:0] saddr;
	logic [31:0] daddr;
	logic [31:0] ports;
	logic [63:0] seqack;
	logic [31:0] ofw;
	logic [47:0] head;

	result_t summaries_due[$];

	task automatic clear_packet();
		rx_count = '0;
		ver_ihl  = '0;
		tot_len  = '0;
		proto    = '0;
		saddr    = '0;
		daddr    = '0;
		ports    = '0;
		seqack   = '0;
		ofw      = '0;
		head     = '0;
	endtask

	// capture one byte at position pos of the packet
	task automatic absorb_byte(input int pos, input logic [7:0] b);
		int hl;
		int r;
		int ps;
		int doff;
		bit have_ps;
		hl = ver_ihl[3:0] * 4;
		if (pos == 0) ver_ihl = b;
		else if (pos == 2) tot_len[15:8] = b;
		else if (pos == 3) tot_len[7:0] = b;
		else if (pos == 9) proto = b;
		else if (pos >= 12 && pos < 16) saddr[8 * (15 - pos) +: 8] = b;
		else if (pos >= 16 && pos < 20) daddr[8 * (19 - pos) +: 8] = b;

		if (pos < 1 || pos < hl) return;
		r = pos - hl;
		if (r < 4) ports[8 * (3 - r) +: 8] = b;
		else if (r < 12) seqack[8 * (11 - r) +: 8] = b;
		else if (r < 16) ofw[8 * (15 - r) +: 8] = b;

		have_ps = 1'b0;
		ps = 0;
		doff = ofw[31:28] * 4;
		if (proto == PROTO_UDP) begin
			ps = int'(UDP_HDR);
			have_ps = 1'b1;
		end else if (proto == PROTO_TCP && doff >= int'(TCP_MIN_HDR)) begin
			ps = doff;
			have_ps = 1'b1;
		end
		if (have_ps && r >= ps && r - ps < 6) head[8 * (5 - (r - ps)) +: 8] = b;
	endtask

	function automatic result_t summarise();
		result_t s;
		int len;
		int hl;
		int total;
		int l4;
		int doff;
		int plen;
		s = '0;
		len = rx_count;
		hl = ver_ihl[3:0] * 4;
		if (len < int'(IP_MIN_HDR) || ver_ihl[7:4] != IP_VERSION ||
			hl < int'(IP_MIN_HDR) || hl > len) begin
			s.kind = KIND_BAD_IP;
			return s;
		end
		total = (int'(tot_len) > len) ? len : int'(tot_len);
		l4 = total - hl;
		s.protocol = proto;
		s.ip_src = saddr;
		s.ip_dst = daddr;
		if (proto == PROTO_UDP) begin
			if (l4 < int'(UDP_HDR)) begin
				s.kind = KIND_UDP_BAD;
			end else begin
				plen = l4 - int'(UDP_HDR);
				s.kind = KIND_UDP_OK;
				s.l4_sport = ports[31:16];
				s.l4_dport = ports[15:0];
				s.data_len = 16'(plen);
				if (plen >= int'(QUIC_MIN_LEN) && head[47] &&
					(head[39:8] == QUIC_V1 || head[39:8] == QUIC_V2))
					s.payload_class = CLASS_QUIC_INIT;
			end
		end else if (proto == PROTO_TCP) begin
			doff = ofw[31:28] * 4;
			if (l4 < int'(TCP_MIN_HDR) || doff < int'(TCP_MIN_HDR) || doff > l4) begin
				s.kind = KIND_TCP_BAD;
			end else begin
				plen = l4 - doff;
				s.kind = KIND_TCP_OK;
				s.l4_sport = ports[31:16];
				s.l4_dport = ports[15:0];
				s.seq_num = seqack[63:32];
				s.ack_num = seqack[31:0];
				s.tcp_flags = ofw[21:16];
				s.window_size = ofw[15:0];
				s.data_len = 16'(plen);
				if (plen >= int'(TLS_MIN_LEN) && head[47:40] == TLS_HANDSHAKE &&
					head[7:0] == TLS_CLIENT_HELLO)
					s.payload_class = CLASS_TLS_HELLO;
			end
		end else begin
			s.kind = KIND_OTHER;
		end
		return s;
	endfunction

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want) report($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			clear_packet();
			summaries_due.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (result.valid && result.ready) begin
				if (summaries_due.size() == 0) begin
					report("result with no packet awaiting it");
				end else begin
					want = summaries_due.pop_front();
					check_field("kind", 32'(result.kind), 32'(want.kind));
					check_field("protocol", 32'(result.protocol), 32'(want.protocol));
					check_field("ip_src", result.ip_src, want.ip_src);
					check_field("ip_dst", result.ip_dst, want.ip_dst);
					check_field("l4_sport", 32'(result.l4_sport), 32'(want.l4_sport));
					check_field("l4_dport", 32'(result.l4_dport), 32'(want.l4_dport));
					check_field("seq_num", result.seq_num, want.seq_num);
					check_field("ack_num", result.ack_num, want.ack_num);
					check_field("tcp_flags", 32'(result.tcp_flags), 32'(want.tcp_flags));
					check_field("window_size", 32'(result.window_size),
						32'(want.window_size));
					check_field("data_len", 32'(result.data_len), 32'(want.data_len));
					check_field("payload_class", 32'(result.payload_class),
						32'(want.payload_class));
				end
			end
			if (packet.valid && packet.ready) begin
				if (rx_count != COUNT_MAX) begin
					absorb_byte(int'(rx_count), packet.data_byte);
					rx_count++;
				end
				if (packet.end_of_packet) begin
					summaries_due.push_back(summarise());
					clear_packet();
				end
			end
			pending <= summaries_due.size();
		end
	end

endmodule

@@ test/testbench.sv @@
// top of the header parser testbench: clock, reset, packet stimulus and verdict
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ilhp_pkg::*;

	// generous bound, many times the slowest legal run with every stall
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RANDOM_BYTES = 700;
	localparam int RANDOM_PACKETS = 16;
	localparam int CHOKE_PACKETS = 10;
	localparam int CHOKE_CYCLES = 400;

	logic clk;
	logic arst_n = 1'b0;

	ilhp_byte_if   packet ();
	ilhp_result_if result ();

	int mismatches;
	int pending;
	int cycle_count = 0;

	// shared between the sender and the receiver: idling on or off for this stretch
	bit idling = 1'b0;
	// one-shot request for the receiver to hold off for a long stretch
	bit choke_request = 1'b0;

	// bytes of the packet under construction, ip header byte 0 first
	logic [7:0] frame[$];

	ipv4_l4_header_parser i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.packet (packet),
		.result (result)
	);

	header_parse_scoreboard i_scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.packet     (packet),
		.result     (result),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: a hung handshake or a lost result ends here
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// ---------------------------------------------------------------- random helpers

	function automatic logic [7:0] rand8();
		return 8'($urandom_range(0, 255));
	endfunction

	// biased towards the extremes so that all-zero and all-one fields turn up
	function automatic logic [31:0] rand32();
		case ($urandom_range(0, 9))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	// idle length, drawn from one of two ranges: the lower one in most draws, the upper one now and then
	function automatic int gap_len();
		if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
		return $urandom_range(12, 48);
	endfunction

	// ---------------------------------------------------------------- packet building

	// low n bytes of w, most significant first
	task automatic push_word(input logic [31:0] w, input int n);
		for (int i = n - 1; i >= 0; i--) frame.push_back(w[8 * i +: 8]);
	endtask

	task automatic put_random(input int n);
		for (int i = 0; i < n; i++) frame.push_back(rand8());
	endtask

	task automatic set_word(input int pos, input logic [31:0] w, input int n);
		for (int i = 0; i < n; i++) frame[pos + i] = w[8 * (n - 1 - i) +: 8];
	endtask

	task automatic set_total(input int v);
		set_word(2, 32'(v), 2);
	endtask

	// ipv4 header; the 20 fixed bytes always go out, options fill up to ihl words
	task automatic put_ip(input logic [3:0] ver, input logic [3:0] ihl, input logic [7:0] prot);
		frame.push_back({ver, ihl});
		frame.push_back(rand8());
		push_word('0, 2);
		push_word($urandom, 4);
		frame.push_back(rand8());
		frame.push_back(prot);
		push_word($urandom, 2);
		push_word(rand32(), 4);
		push_word(rand32(), 4);
		put_random(ihl * 4 - 20);
	endtask

	task automatic put_udp();
		push_word(rand32(), 2);
		push_word(rand32(), 2);
		push_word($urandom, 4);
	endtask

	task automatic put_tcp(input logic [3:0] doff);
		logic [7:0] r;
		r = rand8();
		push_word(rand32(), 2);
		push_word(rand32(), 2);
		push_word(rand32(), 4);
		push_word(rand32(), 4);
		frame.push_back({doff, r[3:0]});
		push_word(rand32(), 1);
		push_word(rand32(), 2);
		push_word($urandom, 4);
		put_random(doff * 4 - 20);
	endtask

	task automatic put_quic(input logic [31:0] ver, input logic long_hdr, input int tail);
		logic [7:0] first;
		first = rand8();
		first[7] = long_hdr;
		frame.push_back(first);
		push_word(ver, 4);
		put_random(tail);
	endtask

	task automatic put_tls(input logic [7:0] rec, input logic [7:0] hs, input int tail);
		frame.push_back(rec);
		put_random(4);
		frame.push_back(hs);
		put_random(tail);
	endtask

	// total length: mostly honest, sometimes short of or beyond the bytes sent
	task automatic fix_total();
		int pick;
		int v;
		if (frame.size() < 4) return;
		pick = $urandom_range(0, 99);
		if (pick < 70) v = frame.size();
		else if (pick < 85) v = $urandom_range(0, frame.size());
		else v = frame.size() + $urandom_range(1, 200);
		if (v > 65535) v = 65535;
		set_total(v);
	endtask

	task automatic truncate_to(input int n);
		while (frame.size() > n) void'(frame.pop_back());
	endtask

	task automatic put_quic_payload();
		logic [31:0] ver;
		case ($urandom_range(0, 2))
			0: begin
				ver = QUIC_V1;
			end
			1: begin
				ver = QUIC_V2;
			end
			default: begin
				ver = $urandom;
			end
		endcase
		put_quic(ver, $urandom_range(0, 9) != 0, $urandom_range(0, 12));
	endtask

	task automatic put_tls_payload();
		logic [7:0] rec;
		logic [7:0] hs;
		rec = ($urandom_range(0, 9) == 0) ? rand8() : TLS_HANDSHAKE;
		hs = ($urandom_range(0, 9) == 0) ? rand8() : TLS_CLIENT_HELLO;
		put_tls(rec, hs, $urandom_range(0, 12));
	endtask

	task automatic put_l4_payload(input logic [7:0] prot);
		if ($urandom_range(0, 1) == 0) put_random($urandom_range(0, 24));
		else if (prot == PROTO_UDP) put_quic_payload();
		else put_tls_payload();
	endtask

	// mostly well-formed udp / tcp with random content, the rest other protocols, noise and broken headers
	task automatic build_random_frame();
		int pick;
		logic [3:0] ihl;
		logic [3:0] doff;
		logic [7:0] prot;
		frame.delete();
		pick = $urandom_range(0, 99);
		ihl = ($urandom_range(0, 9) < 8) ? 4'd5 : 4'($urandom_range(5, 8));
		doff = ($urandom_range(0, 9) < 8) ? 4'd5 : 4'($urandom_range(5, 8));
		prot = ($urandom_range(0, 1) == 0) ? PROTO_UDP : PROTO_TCP;
		if (pick < 60) begin
			put_ip(IP_VERSION, ihl, prot);
			if (prot == PROTO_UDP) put_udp();
			else put_tcp(doff);
			put_l4_payload(prot);
			fix_total();
			// every so often the packet ends early
			if ($urandom_range(0, 9) == 0) truncate_to($urandom_range(1, frame.size()));
		end else if (pick < 70) begin
			put_ip(IP_VERSION, ihl, rand8());
			put_random($urandom_range(0, 20));
			fix_total();
		end else if (pick < 88) begin
			// broken header fields: random version, ihl and data offset
			put_ip(($urandom_range(0, 1) == 0) ? IP_VERSION : 4'($urandom_range(0, 15)),
				4'($urandom_range(0, 15)), prot);
			if (prot == PROTO_UDP) put_udp();
			else put_tcp(4'($urandom_range(0, 15)));
			put_l4_payload(prot);
			fix_total();
			if ($urandom_range(0, 3) == 0) truncate_to($urandom_range(1, frame.size()));
		end else begin
			put_random($urandom_range(1, 40));
			if ($urandom_range(0, 1) == 0) frame[0] = {IP_VERSION, 4'd5};
		end
	endtask

	// ---------------------------------------------------------------- driving

	// one byte request, starting and ending at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic eop);
		int gap;
		gap = (idling && $urandom_range(0, 99) < 20) ? gap_len() : 0;
		if (gap > 0) begin
			packet.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		packet.valid <= 1'b1;
		packet.data_byte <= b;
		packet.end_of_packet <= eop;
		do @(posedge clk); while (!packet.ready);
		@(negedge clk);
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame.size(); i++) send_byte(frame[i], i == frame.size() - 1);
	endtask

	// receiver: random stalls while idling, plus the long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		result.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (choke_request) begin
				choke_request = 1'b0;
				hold_left = CHOKE_CYCLES;
			end
			if (hold_left > 0) begin
				result.ready <= 1'b0;
				hold_left--;
			end else if (idling && $urandom_range(0, 99) < 25) begin
				result.ready <= 1'b0;
				hold_left = gap_len() - 1;
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- directed cases

	task automatic run_directed();
		// single byte: far too short for an ip header
		frame.delete();
		frame.push_back({IP_VERSION, 4'd5});
		send_frame();

		// one byte short of a minimal header
		frame.delete();
		put_ip(IP_VERSION, 4'd5, PROTO_UDP);
		truncate_to(19);
		set_total(19);
		send_frame();

		// wrong ip version
		frame.delete();
		put_ip(4'd6, 4'd5, PROTO_UDP);
		put_udp();
		set_total(frame.size());
		send_frame();

		// ihl below five words
		frame.delete();
		put_ip(IP_VERSION, 4'd4, PROTO_UDP);
		put_udp();
		set_total(frame.size());
		send_frame();

		// ihl of zero: l4 capture starts right after byte 0
		frame.delete();
		put_ip(IP_VERSION, 4'd0, PROTO_TCP);
		put_tcp(4'd5);
		set_total(frame.size());
		send_frame();

		// ihl reaching past the end of the packet
		frame.delete();
		put_ip(IP_VERSION, 4'd15, PROTO_TCP);
		truncate_to(40);
		set_total(60);
		send_frame();

		// neither tcp nor udp
		frame.delete();
		put_ip(IP_VERSION, 4'd5, 8'd1);
		put_random(8);
		set_total(frame.size());
		send_frame();

		// udp with too few l4 bytes
		frame.delete();
		put_ip(IP_VERSION, 4'd5, PROTO_UDP);
		put_random(3);
		set_total(frame.size());
		send_frame();

		// total length of zero: negative l4 length
		frame.delete();
		put_ip(IP_VERSION, 4'd5, PROTO_UDP);
		put_udp();
		put_random(6);
		set_total(0);
		send_frame();

		// quic v1 initial, all-one addresses and ports
		frame.delete();
		put_ip(IP_VERSION, 4'd5, PROTO_UDP);
		put_udp();
		put_quic(QUIC_V1, 1'b1, 10);
		set_total(frame.size());
		set_word(12, '1, 4);
		set_word(16, '1, 4);
		set_word(20, '1, 4);
		send_frame();

		// quic v2 initial, all-zero addresses and ports
		frame.delete();
		put_ip(IP_VERSION, 4'd5, PROTO_UDP);
		put_udp();
		put_quic(QUIC_V2, 1'b1, 0);
		set_total(frame.size());
		set_word(12, '0, 4);
		set_word(16, '0, 4);
		set_word(20, '0, 4);
		send_frame();

		// short header form: no quic initial
		frame.delete();
		put_ip(IP_VERSION, 4'd5, PROTO_UDP);
		put_udp();
		put_quic(QUIC_V1, 1'b0, 4);
		set_total(frame.size());
		send_frame();

		// quic initial cut to four payload bytes by the total length
		frame.delete();
		put_ip(IP_VERSION, 4'd5, PROTO_UDP);
		put_udp();
		put_quic(QUIC_V1, 1'b1, 3);
		set_total(32);
		send_frame();

		// total length far beyond the bytes received: clamped
		frame.delete();
		put_ip(IP_VERSION, 4'd5, PROTO_UDP);
		put_udp();
		put_random(9);
		set_total(16'hFFFF);
		send_frame();

		// tls clienthello with all-one sequence, ack and flag byte
		frame.delete();
		put_ip(IP_VERSION, 4'd5, PROTO_TCP);
		put_tcp(4'd5);
		put_tls(TLS_HANDSHAKE, TLS_CLIENT_HELLO, 5);
		set_total(frame.size());
		set_word(24, '1, 4);
		set_word(28, '1, 4);
		set_word(33, '1, 1);
		send_frame();

		// tls clienthello cut to five payload bytes
		frame.delete();
		put_ip(IP_VERSION, 4'd5, PROTO_TCP);
		put_tcp(4'd5);
		put_tls(TLS_HANDSHAKE, TLS_CLIENT_HELLO, 3);
		set_total(45);
		send_frame();

		// tcp data offset below five words
		frame.delete();
		put_ip(IP_VERSION, 4'd5, PROTO_TCP);
		put_tcp(4'd4);
		put_random(8);
		set_total(frame.size());
		send_frame();

		// tcp data offset reaching past the l4 length
		frame.delete();
		put_ip(IP_VERSION, 4'd5, PROTO_TCP);
		put_tcp(4'd15);
		put_random(4);
		set_total(60);
		send_frame();

		// tcp with too few l4 bytes
		frame.delete();
		put_ip(IP_VERSION, 4'd5, PROTO_TCP);
		put_random(10);
		set_total(frame.size());
		send_frame();

		// ip and tcp options in front of a clienthello
		frame.delete();
		put_ip(IP_VERSION, 4'd6, PROTO_TCP);
		put_tcp(4'd6);
		put_tls(TLS_HANDSHAKE, TLS_CLIENT_HELLO, 8);
		set_total(frame.size());
		send_frame();

		// all-one and all-zero bytes
		frame.delete();
		for (int i = 0; i < 30; i++) frame.push_back(8'hFF);
		send_frame();
		frame.delete();
		for (int i = 0; i < 30; i++) frame.push_back(8'h00);
		send_frame();
	endtask

	// ---------------------------------------------------------------- main sequence

	initial begin
		int random_bytes;
		int random_packets;
		packet.valid = 1'b0;
		packet.data_byte = '0;
		packet.end_of_packet = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		idling = 1'b1;
		run_directed();

		// back-pressure: receiver holds off while short packets keep coming
		// without gaps, so both result stages fill and the byte input stalls
		idling = 1'b0;
		choke_request = 1'b1;
		for (int n = 0; n < CHOKE_PACKETS; n++) begin
			frame.delete();
			put_ip(IP_VERSION, 4'd5, PROTO_UDP);
			put_udp();
			put_random($urandom_range(0, 4));
			set_total(frame.size());
			send_frame();
		end

		// random packets; idling switched per stretch of eight packets
		random_bytes = 0;
		random_packets = 0;
		while (random_bytes < RANDOM_BYTES || random_packets < RANDOM_PACKETS) begin
			if (random_packets % 8 == 0) idling = ($urandom_range(0, 3) != 0);
			build_random_frame();
			send_frame();
			random_bytes += frame.size();
			random_packets++;
		end
		packet.valid <= 1'b0;
		idling = 1'b1;

		// drain: every predicted summary has to come out, then the bench idles before the verdict
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

@@ ipv4_l4_header_parser.f @@
hw/rtl/ilhp_pkg.sv
hw/rtl/ilhp_if.sv
hw/rtl/ilhp_capture.sv
hw/rtl/ilhp_classify.sv
hw/rtl/ipv4_l4_header_parser.sv
test/header_parse_scoreboard.sv
test/testbench.sv
